// File: sv/wvbi_pkg.sv
package wvbi_pkg;

    localparam int FRAC_BITS_DEF  = 12;
    localparam int SPEED_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int STEPS          = 30;
    localparam int GAIN_Q12       = 2487;
    localparam int LANES          = 4;
    // component width: speed*2487 grows below 2^(16+12), cordic growth < 2 bits
    localparam int CW             = 36;

    typedef struct packed {
        logic [15:0] dir_a;
        logic [15:0] speed_a;
        logic [15:0] dir_b;
        logic [15:0] speed_b;
        logic [15:0] dir_c;
        logic [15:0] speed_c;
        logic [15:0] dir_d;
        logic [15:0] speed_d;
        logic [12:0] frac_x;
        logic [12:0] frac_y;
    } in_word_t;

    typedef struct packed {
        logic [15:0] wind_speed;
        logic [15:0] wind_direction;
        logic        calm;
    } out_word_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
            27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

// File: sv/wvbi_rot_lane.sv
// pipelined rotation cordic: one corner's direction and speed to east/north
module wvbi_rot_lane
#(
    parameter int SPEED_BITS = wvbi_pkg::SPEED_BITS_DEF,
    parameter int ANGLE_BITS = wvbi_pkg::ANGLE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic [15:0]                 dir,
    input  logic [15:0]                 speed,
    output logic signed [wvbi_pkg::CW-1:0] east,
    output logic signed [wvbi_pkg::CW-1:0] north
);
    import wvbi_pkg::*;

    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [33:0]   z_reg [STEPS+1];

    logic [31:0]          a_w;
    logic signed [33:0]   z0;
    logic signed [CW-1:0] x0;
    logic [SPEED_BITS-1:0] s_w;

    // pre-rotation into the right half plane
    always_comb
    begin
        a_w = 32'(({16'd0, dir} & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS));
        s_w = SPEED_BITS'({16'd0, speed});
        z0  = $signed({{2{a_w[31]}}, a_w});
        x0  = CW'($signed({1'b0, s_w}) * GAIN_Q12);
        if (z0 > 34'sd1073741824)
        begin
            x0 = -x0;
            z0 = z0 - 34'sd2147483648;
        end
        else if (z0 < -34'sd1073741824)
        begin
            x0 = -x0;
            z0 = z0 + 34'sd2147483648;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x0;
        y_reg[0] <= '0;
        z_reg[0] <= z0;
    end

    // one iteration per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - $signed({2'b00, atan_turn(i)});
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + $signed({2'b00, atan_turn(i)});
            end
        end
    end

    assign north = x_reg[STEPS];
    assign east  = y_reg[STEPS];
endmodule

// File: sv/wvbi_merge.sv
// bilinear blend of the four lanes, then vectoring cordic back to polar
module wvbi_merge
#(
    parameter int FRAC_BITS  = wvbi_pkg::FRAC_BITS_DEF,
    parameter int SPEED_BITS = wvbi_pkg::SPEED_BITS_DEF,
    parameter int ANGLE_BITS = wvbi_pkg::ANGLE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic signed [wvbi_pkg::CW-1:0] e_in [wvbi_pkg::LANES],
    input  logic signed [wvbi_pkg::CW-1:0] n_in [wvbi_pkg::LANES],
    input  logic [FRAC_BITS:0]             fx,
    input  logic [FRAC_BITS:0]             fy,
    output wvbi_pkg::out_word_t            result
);
    import wvbi_pkg::*;

    localparam int PW = CW + FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam int VW = CW + 2;

    function automatic logic signed [CW-1:0] blend(input logic signed [CW-1:0] p,
        input logic signed [CW-1:0] q, input logic [FRAC_BITS:0] w);
        logic signed [PW-1:0] acc;
        acc = PW'(p) * $signed({1'b0, ONE - w}) + PW'(q) * $signed({1'b0, w})
            + PW'($signed({1'b0, ONE >> 1}));
        return CW'(acc >>> FRAC_BITS);
    endfunction

    // row blends along x
    logic signed [CW-1:0] e0_reg, e1_reg, n0_reg, n1_reg;
    logic [FRAC_BITS:0]   fy_reg;
    always_ff @(posedge clk)
    begin
        e0_reg <= blend(e_in[0], e_in[1], fx);
        e1_reg <= blend(e_in[2], e_in[3], fx);
        n0_reg <= blend(n_in[0], n_in[1], fx);
        n1_reg <= blend(n_in[2], n_in[3], fx);
        fy_reg <= fy;
    end

    // column blend along y
    logic signed [CW-1:0] e_reg, n_reg;
    always_ff @(posedge clk)
    begin
        e_reg <= blend(e0_reg, e1_reg, fy_reg);
        n_reg <= blend(n0_reg, n1_reg, fy_reg);
    end

    // vectoring pipeline
    logic signed [VW-1:0] vx_reg [STEPS+1];
    logic signed [VW-1:0] vy_reg [STEPS+1];
    logic [31:0]          vz_reg [STEPS+1];
    logic                 calm_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        calm_reg[0] <= (e_reg == 0) && (n_reg == 0);
        if (n_reg < 0)
        begin
            vx_reg[0] <= -VW'(n_reg);
            vy_reg[0] <= -VW'(e_reg);
            vz_reg[0] <= 32'h8000_0000;
        end
        else
        begin
            vx_reg[0] <= VW'(n_reg);
            vy_reg[0] <= VW'(e_reg);
            vz_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            calm_reg[i+1] <= calm_reg[i];
            if (vy_reg[i] > 0)
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] + atan_turn(i);
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] - atan_turn(i);
            end
        end
    end

    // gain multiply registered, then round and saturate
    logic [VW+12-1:0] prod_reg;
    logic [31:0]      z_fin_reg;
    logic             calm_fin_reg;
    always_ff @(posedge clk)
    begin
        prod_reg     <= (vx_reg[STEPS] > 0)
                      ? (VW+12)'($unsigned(vx_reg[STEPS])) * (VW+12)'(GAIN_Q12) : '0;
        z_fin_reg    <= vz_reg[STEPS];
        calm_fin_reg <= calm_reg[STEPS];
    end

    logic [VW+12-1:0] spd_w;
    logic [32:0]      dir_w;
    logic [SPEED_BITS-1:0] smax;
    always_comb
    begin
        smax  = '1;
        spd_w = (prod_reg + ((VW+12)'(1) << 23)) >> 24;
        if (spd_w > (VW+12)'(smax))
            spd_w = (VW+12)'(smax);
        dir_w = ({1'b0, z_fin_reg} + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        dir_w = dir_w & ((33'd1 << ANGLE_BITS) - 33'd1);
        if (calm_fin_reg)
        begin
            result.wind_speed     = '0;
            result.wind_direction = '0;
            result.calm           = 1'b1;
        end
        else
        begin
            result.wind_speed     = 16'(spd_w);
            result.wind_direction = 16'(dir_w);
            result.calm           = 1'b0;
        end
    end
endmodule

// File: sv/wind_vector_bilinear_interp.sv
// wind vector bilinear interpolation
// input channel: raise start with word_in for one cycle; busy is always low,
//   so a new word may be given on every clock cycle
// output channel: done pulses for one cycle with word_out valid; the
//   receiver cannot stall, so each result must be taken when shown
// latency: 66 cycles from the accepting edge to the result edge
//   (1 + 30 rotation stages, 2 blend stages, 1 + 30 vectoring stages,
//   1 gain multiply stage, output register)
// throughput: one word per cycle, set by the fully pipelined cordic lanes
// four rotation lanes run in parallel, one per grid corner; a merge stage
// blends them and converts back to speed and direction
// reset: clears the valid shift line only; words in flight are dropped
module wind_vector_bilinear_interp
#(
    parameter int FRAC_BITS  = wvbi_pkg::FRAC_BITS_DEF,
    parameter int SPEED_BITS = wvbi_pkg::SPEED_BITS_DEF,
    parameter int ANGLE_BITS = wvbi_pkg::ANGLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  wvbi_pkg::in_word_t  word_in,
    output logic                done,
    output wvbi_pkg::out_word_t word_out
);
    import wvbi_pkg::*;

    localparam int LAT = (STEPS + 1) + 2 + (STEPS + 1) + 1 + 1;

    logic [15:0] dirs [LANES];
    logic [15:0] spds [LANES];
    logic signed [CW-1:0] e_w [LANES];
    logic signed [CW-1:0] n_w [LANES];

    assign dirs[0] = word_in.dir_a;  assign spds[0] = word_in.speed_a;
    assign dirs[1] = word_in.dir_b;  assign spds[1] = word_in.speed_b;
    assign dirs[2] = word_in.dir_c;  assign spds[2] = word_in.speed_c;
    assign dirs[3] = word_in.dir_d;  assign spds[3] = word_in.speed_d;

    // one rotation lane per corner
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        wvbi_rot_lane #(.SPEED_BITS(SPEED_BITS), .ANGLE_BITS(ANGLE_BITS)) u_lane
        (
            .clk(clk), .dir(dirs[l]), .speed(spds[l]),
            .east(e_w[l]), .north(n_w[l])
        );
    end

    // fraction clamp, delayed to meet the lane outputs
    function automatic logic [FRAC_BITS:0] clamp(input logic [12:0] f);
        logic [FRAC_BITS+1:0] m;
        m = (FRAC_BITS+2)'({19'd0, f}) & ((FRAC_BITS+2)'(1) << (FRAC_BITS+1)) - 1'b1;
        if (m > ((FRAC_BITS+2)'(1) << FRAC_BITS))
            m = (FRAC_BITS+2)'(1) << FRAC_BITS;
        return (FRAC_BITS+1)'(m);
    endfunction

    logic [FRAC_BITS:0] fx_reg [STEPS+1];
    logic [FRAC_BITS:0] fy_reg [STEPS+1];
    always_ff @(posedge clk)
    begin
        fx_reg[0] <= clamp(word_in.frac_x);
        fy_reg[0] <= clamp(word_in.frac_y);
        for (int i = 0; i < STEPS; i++)
        begin
            fx_reg[i+1] <= fx_reg[i];
            fy_reg[i+1] <= fy_reg[i];
        end
    end

    out_word_t res_w;
    wvbi_merge #(.FRAC_BITS(FRAC_BITS), .SPEED_BITS(SPEED_BITS), .ANGLE_BITS(ANGLE_BITS))
    u_merge
    (
        .clk(clk), .e_in(e_w), .n_in(n_w),
        .fx(fx_reg[STEPS]), .fy(fy_reg[STEPS]), .result(res_w)
    );

    // valid shift line and output register
    logic [LAT-2:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-3:0], start};
            done    <= vld_reg[LAT-2];
        end
    end

    always_ff @(posedge clk)
    begin
        word_out <= res_w;
    end

    assign busy = 1'b0;
endmodule

// File: sv/wvbi_checker.sv
// port-level checks for the interpolator
module wvbi_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input wvbi_pkg::out_word_t word_out
);
    // a calm word carries zero speed and direction
    a_calm: assert property (@(posedge clk) disable iff (!rst_n)
        done && word_out.calm |-> word_out.wind_speed == 0 && word_out.wind_direction == 0)
        else $error("calm word not zero");

    // block never stalls the sender
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // result follows an accepted word after the pipeline latency
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##66 done)
        else $error("result missing");
endmodule

bind wind_vector_bilinear_interp wvbi_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .word_out(word_out)
);
